// File: sv/rkl_pkg.sv
// Shared types and fixed-point constants for the ladder low-pass filter.
// Used by rkl_mul, the top level and the testbench.
`default_nettype none
package rkl_pkg;

    // Register indexes of the configuration port
    localparam logic [1:0] REG_STEP_GAIN = 2'd0;
    localparam logic [1:0] REG_RESONANCE = 2'd1;
    localparam logic [1:0] REG_GAIN_COMP = 2'd2;

    localparam logic [15:0] STEP_GAIN_RST = 16'd6554;

    // Q.24 unity and soft clip limits
    localparam int ONE_Q24   = 16777216;
    localparam int CLIP_SPAN = 50331648;   // 3.0 in Q.24
    localparam int CLIP_WMAX = 100663296;  // 6.0 in Q.24

    // floor(w/3) = (w * RECIP3) >> 31 for 0 <= w < 2^31
    localparam int RECIP3    = 715827883;
    // Bias that keeps the divide-by-three operand of the stage update positive
    localparam int UPD_OFF   = 805306368;  // 3 * 2^28
    localparam int UPD_BIAS  = 268435456;  // 2^28

    // Output window taps in Q.24
    localparam int W_TAP0 = -1068447;
    localparam int W_TAP2 = 9616015;
    localparam int W_TAP3 = 16777216;

    // Post-multiply shift amounts
    localparam logic [4:0] SH_NONE  = 5'd0;
    localparam logic [4:0] SH_FB    = 5'd13;
    localparam logic [4:0] SH_FULL  = 5'd16;
    localparam logic [4:0] SH_HALF  = 5'd17;
    localparam logic [4:0] SH_Q24   = 5'd24;
    localparam logic [4:0] SH_RECIP = 5'd31;

    localparam int OUT_MAX = 8388607;
    localparam int OUT_MIN = -8388608;

    typedef struct packed {
        logic signed [35:0] a;
        logic signed [30:0] b;
        logic        [4:0]  sh;
    } t_mul_op;

endpackage
`default_nettype wire

// File: sv/rkl_mul.sv
// Shared multiply and arithmetic-shift unit with a registered product.
// Depends on rkl_pkg for the operation struct.
`default_nettype none
module rkl_mul (
    input  wire                   i_clk,
    input  wire rkl_pkg::t_mul_op i_op,
    output logic signed [63:0]    o_prod
);
    import rkl_pkg::*;

    logic signed [66:0] full;
    logic signed [66:0] shifted;
    logic signed [63:0] r_prod;

    assign full    = i_op.a * i_op.b;
    // arithmetic shift gives floor division by the power of two
    assign shifted = full >>> i_op.sh;

    always_ff @(posedge i_clk) begin
        r_prod <= shifted[63:0];
    end

    assign o_prod = r_prod;

endmodule
`default_nettype wire

// File: sv/rk4_ladder_lowpass_filter.sv
// Four-stage ladder low-pass filter, RK4 at four sub-steps per sample.
// Depends on rkl_pkg and the shared multiplier rkl_mul.
//
// channel   direction  handshake                    payload
// in        slave      i_in_valid / o_in_stall      i_sample_in  (Q4.20)
// out       master     o_out_valid / i_out_stall    o_sample_out (Q4.20)
// cfg       slave      i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// One sample's work is four sub-steps plus intake, window and output, and every
// product goes through one multiplier.
// o_in_stall is high from acceptance until the result is loaded into the output
// register; a sample can be taken while that result waits on i_out_stall.
// Reset (synchronous, active low) clears the stages and loads register defaults.
`default_nettype none
module rk4_ladder_lowpass_filter (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_stall,
    input  wire signed [23:0]  i_sample_in,
    output logic               o_out_valid,
    input  wire                i_out_stall,
    output logic signed [23:0] o_sample_out,
    input  wire                i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire        [1:0]   i_cfg_index,
    input  wire        [15:0]  i_cfg_data
);
    import rkl_pkg::*;

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_CX    = 5'd1;
    localparam logic [4:0] ST_CXW   = 5'd2;
    localparam logic [4:0] ST_FB    = 5'd3;
    localparam logic [4:0] ST_CDIV  = 5'd4;
    localparam logic [4:0] ST_CSQ   = 5'd5;
    localparam logic [4:0] ST_CCUBE = 5'd6;
    localparam logic [4:0] ST_CFIN  = 5'd7;
    localparam logic [4:0] ST_G     = 5'd8;
    localparam logic [4:0] ST_K     = 5'd9;
    localparam logic [4:0] ST_KW    = 5'd10;
    localparam logic [4:0] ST_U     = 5'd11;
    localparam logic [4:0] ST_UD    = 5'd12;
    localparam logic [4:0] ST_UW    = 5'd13;
    localparam logic [4:0] ST_W0    = 5'd14;
    localparam logic [4:0] ST_W1    = 5'd15;
    localparam logic [4:0] ST_W2    = 5'd16;
    localparam logic [4:0] ST_W3    = 5'd17;
    localparam logic [4:0] ST_FIN   = 5'd18;

    localparam logic [2:0] HEAD_IDX = 3'd4;

    logic [4:0]  r_state, n_state;
    logic [2:0]  r_j;
    logic [1:0]  r_i, r_e, r_os;

    logic [15:0] r_step_gain, r_resonance, r_gain_comp;

    logic signed [31:0] r_s [4];
    logic signed [33:0] r_t [4];
    logic signed [27:0] r_x, r_cx;
    logic signed [25:0] r_u;
    logic signed [26:0] r_clip [5];
    logic signed [30:0] r_gacc [4];
    logic signed [31:0] r_tap0, r_tap2, r_tap3;
    logic signed [59:0] r_acc;
    logic               r_out_valid;
    logic signed [23:0] r_sample_out;

    logic signed [63:0] prod;
    t_mul_op            mop;

    logic               in_take, out_free;
    logic signed [33:0] t_sel;
    logic signed [40:0] v_clip, w_ext;
    logic        [26:0] w_clip;
    logic signed [26:0] u_wide;
    logic signed [25:0] u_new;
    logic signed [27:0] clip_w;
    logic signed [35:0] d_fb;
    logic signed [27:0] g [4];
    logic signed [31:0] upd_w;
    logic signed [29:0] upd_d;
    logic signed [33:0] s_sum, t_half;
    logic signed [31:0] s_sat;
    logic signed [59:0] acc_add;
    logic signed [61:0] acc3;
    logic signed [32:0] y_w;
    logic signed [23:0] y_sat;

    rkl_mul u_mul (
        .i_clk  (i_clk),
        .i_op   (mop),
        .o_prod (prod)
    );

    assign in_take  = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    // soft clip operand: head input or one of the stage points
    assign t_sel = r_t[r_j[1:0]];
    always_comb begin
        if (r_j == HEAD_IDX) begin
            v_clip = 41'(r_x) - 41'(signed'(prod[37:0]));
        end else begin
            v_clip = 41'(t_sel);
        end
        w_ext = v_clip + 41'(CLIP_SPAN);
        if (w_ext < 0) begin
            w_clip = '0;
        end else if (w_ext > 41'(CLIP_WMAX)) begin
            w_clip = 27'(CLIP_WMAX);
        end else begin
            w_clip = w_ext[26:0];
        end
    end

    assign u_wide = signed'(prod[26:0]) - 27'(ONE_Q24);
    assign u_new  = u_wide[25:0];
    assign clip_w = (28'(r_u) <<< 1) + 28'(r_u) - 28'(signed'(prod[25:0]));
    assign d_fb   = 36'(r_t[3]) - 36'(r_cx);

    always_comb begin
        g[0] = 28'(r_clip[4]) - 28'(r_clip[0]);
        g[1] = 28'(r_clip[0]) - 28'(r_clip[1]);
        g[2] = 28'(r_clip[1]) - 28'(r_clip[2]);
        g[3] = 28'(r_clip[2]) - 28'(r_clip[3]);
    end

    // stage update: floor(q/6) as floor(floor(q/2)/3), biased positive
    assign upd_w  = 32'(signed'(prod[29:1])) + 32'(UPD_OFF);
    assign upd_d  = signed'(prod[29:0]) - 30'(UPD_BIAS);
    assign s_sum  = 34'(r_s[r_i]) + 34'(upd_d);
    assign t_half = 34'(r_s[r_i]) + 34'(signed'(prod[27:0]));

    always_comb begin
        if (s_sum > 34'sd2147483647) begin
            s_sat = 32'sh7FFFFFFF;
        end else if (s_sum < -34'sd2147483648) begin
            s_sat = 32'sh80000000;
        end else begin
            s_sat = s_sum[31:0];
        end
    end

    assign acc_add = 60'(signed'(prod[57:0]));
    assign acc3    = (62'(r_acc) <<< 1) + 62'(r_acc);
    assign y_w     = acc3[61:29];
    always_comb begin
        if (y_w > 33'(OUT_MAX)) begin
            y_sat = 24'(OUT_MAX);
        end else if (y_w < 33'(OUT_MIN)) begin
            y_sat = 24'(OUT_MIN);
        end else begin
            y_sat = y_w[23:0];
        end
    end

    // multiplier operand select
    always_comb begin
        mop = '0;
        case (r_state)
            ST_CX: begin
                mop.a  = 36'(r_gain_comp);
                mop.b  = 31'(r_x);
                mop.sh = SH_FULL;
            end
            ST_FB: begin
                mop.a  = d_fb;
                mop.b  = 31'(r_resonance);
                mop.sh = SH_FB;
            end
            ST_CDIV: begin
                mop.a  = 36'(w_clip);
                mop.b  = 31'(RECIP3);
                mop.sh = SH_RECIP;
            end
            ST_CSQ: begin
                mop.a  = 36'(u_new);
                mop.b  = 31'(u_new);
                mop.sh = SH_Q24;
            end
            ST_CCUBE: begin
                mop.a  = 36'(signed'(prod[25:0]));
                mop.b  = 31'(r_u);
                mop.sh = SH_Q24;
            end
            ST_K: begin
                mop.a  = 36'(r_step_gain);
                mop.b  = 31'(g[r_i]);
                mop.sh = (r_e == 2'd2) ? SH_FULL : SH_HALF;
            end
            ST_U: begin
                mop.a  = 36'(r_step_gain);
                mop.b  = r_gacc[r_i];
                mop.sh = SH_FULL;
            end
            ST_UD: begin
                mop.a  = 36'(upd_w);
                mop.b  = 31'(RECIP3);
                mop.sh = SH_RECIP;
            end
            ST_W0: begin
                mop.a  = 36'(r_tap0);
                mop.b  = 31'(W_TAP0);
                mop.sh = SH_NONE;
            end
            ST_W1: begin
                mop.a  = 36'(r_tap2);
                mop.b  = 31'(W_TAP2);
                mop.sh = SH_NONE;
            end
            ST_W2: begin
                mop.a  = 36'(r_tap3);
                mop.b  = 31'(W_TAP3);
                mop.sh = SH_NONE;
            end
            default: begin
                mop = '0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (in_take) n_state = ST_CX;
            ST_CX:    n_state = ST_CXW;
            ST_CXW:   n_state = ST_FB;
            ST_FB:    n_state = ST_CDIV;
            ST_CDIV:  n_state = ST_CSQ;
            ST_CSQ:   n_state = ST_CCUBE;
            ST_CCUBE: n_state = ST_CFIN;
            ST_CFIN:  n_state = (r_j == 3'd3) ? ST_G : ST_CDIV;
            ST_G:     n_state = (r_e == 2'd3) ? ST_U : ST_K;
            ST_K:     n_state = ST_KW;
            ST_KW:    n_state = (r_i == 2'd3) ? ST_FB : ST_K;
            ST_U:     n_state = ST_UD;
            ST_UD:    n_state = ST_UW;
            ST_UW: begin
                if (r_i != 2'd3) begin
                    n_state = ST_U;
                end else if (r_os == 2'd3) begin
                    n_state = ST_W0;
                end else begin
                    n_state = ST_FB;
                end
            end
            ST_W0:    n_state = ST_W1;
            ST_W1:    n_state = ST_W2;
            ST_W2:    n_state = ST_W3;
            ST_W3:    n_state = ST_FIN;
            ST_FIN:   if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // control, stage state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_step_gain <= STEP_GAIN_RST;
            r_resonance <= '0;
            r_gain_comp <= '0;
            for (int n = 0; n < 4; n++) begin
                r_s[n] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_STEP_GAIN: r_step_gain <= i_cfg_data;
                    REG_RESONANCE: r_resonance <= i_cfg_data;
                    REG_GAIN_COMP: r_gain_comp <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == ST_UW) begin
                r_s[r_i] <= s_sat;
            end
            if (r_state == ST_FIN && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath and loop counters
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (in_take) begin
                    r_x  <= {i_sample_in, 4'b0000};
                    r_e  <= '0;
                    r_os <= '0;
                    for (int n = 0; n < 4; n++) begin
                        r_t[n] <= 34'(r_s[n]);
                    end
                end
            end
            ST_CXW: r_cx <= prod[27:0];
            ST_FB:  r_j  <= HEAD_IDX;
            ST_CSQ: r_u  <= u_new;
            ST_CFIN: begin
                r_clip[r_j] <= clip_w[26:0];
                r_j <= (r_j == HEAD_IDX) ? 3'd0 : r_j + 3'd1;
            end
            ST_G: begin
                r_i <= '0;
                for (int n = 0; n < 4; n++) begin
                    if (r_e == 2'd0) begin
                        r_gacc[n] <= 31'(g[n]);
                    end else if (r_e == 2'd3) begin
                        r_gacc[n] <= r_gacc[n] + 31'(g[n]);
                    end else begin
                        r_gacc[n] <= r_gacc[n] + (31'(g[n]) <<< 1);
                    end
                end
            end
            ST_KW: begin
                r_t[r_i] <= t_half;
                r_i <= r_i + 2'd1;
                if (r_i == 2'd3) begin
                    r_e <= r_e + 2'd1;
                end
            end
            ST_UW: begin
                r_t[r_i] <= 34'(s_sat);
                r_i <= r_i + 2'd1;
                if (r_i == 2'd3) begin
                    // input is zero-stuffed after the first sub-step
                    r_x  <= '0;
                    r_cx <= '0;
                    r_e  <= '0;
                    r_os <= r_os + 2'd1;
                    case (r_os)
                        2'd0:    r_tap0 <= s_sat;
                        2'd2:    r_tap2 <= s_sat;
                        2'd3:    r_tap3 <= s_sat;
                        default: ;
                    endcase
                end
            end
            ST_W1: r_acc <= acc_add;
            ST_W2: r_acc <= r_acc + acc_add;
            ST_W3: r_acc <= r_acc + acc_add;
            ST_FIN: begin
                if (out_free) begin
                    r_sample_out <= y_sat;
                end
            end
            default: ;
        endcase
    end

    assign o_in_stall   = (r_state != ST_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_sample_out;
    assign o_cfg_ready  = 1'b1;

endmodule
`default_nettype wire

// File: sv/rkl_checker.sv
// Port-level checks for the ladder filter top level, attached by bind.
// Sees only the ports of rk4_ladder_lowpass_filter.
`default_nettype none
module rkl_checker (
    input wire               i_clk,
    input wire               i_rst_n,
    input wire               i_in_valid,
    input wire               o_in_stall,
    input wire               o_out_valid,
    input wire               i_out_stall,
    input wire signed [23:0] o_sample_out
);

    // reset leaves no result pending and the input open
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("outputs not cleared by reset");

    // an accepted beat holds the input closed while it is worked on
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input reopened right after a beat");

    // a new result only appears at the end of work on a beat
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without a beat in progress");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_sample_out)))
        else $error("stalled result changed");

endmodule

bind rk4_ladder_lowpass_filter rkl_checker u_rkl_checker (.*);
`default_nettype wire

// File: tb/rk4_ladder_lowpass_filter_tb.sv
// Self-checking testbench for the RK4 ladder low-pass filter: random and directed
// samples across several register settings, checked against a built-in predictor.
// Depends on rkl_pkg and the rk4_ladder_lowpass_filter RTL.
`timescale 1ns / 100ps
module rk4_ladder_lowpass_filter_tb;
    import rkl_pkg::*;

    typedef longint t_lane[4];

    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 20000;
    localparam int LONG_HOLD = 3000;
    localparam int SETTLE = 600;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic signed [23:0] i_sample_in = '0;
    logic               i_out_stall = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic        [1:0]  i_cfg_index = '0;
    logic        [15:0] i_cfg_data = '0;
    wire                o_in_stall;
    wire                o_out_valid;
    wire signed  [23:0] o_sample_out;
    wire                o_cfg_ready;

    rk4_ladder_lowpass_filter dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_sample_in(i_sample_in),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_sample_out(o_sample_out),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // predictor state and register copies
    longint      ladder[4];
    logic [15:0] cut_gain, res_amt, comp_amt;

    logic signed [23:0] sample_q[$];
    logic signed [23:0] filtered_q[$];
    int  mismatches = 0;
    int  idle_cycles = 0;
    bit  in_took = 1'b0;
    bit  running = 1'b0;
    int  snd_idle = 0, rcv_idle = 0;
    int  hold_req = 0, hold_ack = 0, hold_left = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint fdiv(longint a, longint d);
        longint q;
        q = a / d;
        if ((a % d) != 0 && a < 0) q = q - 1;
        return q;
    endfunction

    function automatic longint soft_clip(longint v);
        longint u, u2, u3;
        u = fdiv(v, 3);
        if (u > ONE_Q24) u = ONE_Q24;
        if (u < -ONE_Q24) u = -ONE_Q24;
        u2 = fdiv(u * u, ONE_Q24);
        u3 = fdiv(u2 * u, ONE_Q24);
        return 3 * u - u3;
    endfunction

    function automatic void ladder_slopes(input t_lane s, input longint x, output t_lane g);
        longint c[4];
        longint d, fb, head;
        for (int i = 0; i < 4; i++) c[i] = soft_clip(s[i]);
        d = s[3] - fdiv(longint'(comp_amt) * x, 65536);
        fb = fdiv(longint'(res_amt) * d, 8192);
        head = soft_clip(x - fb);
        g[0] = head - c[0];
        g[1] = c[0] - c[1];
        g[2] = c[1] - c[2];
        g[3] = c[2] - c[3];
    endfunction

    function automatic logic signed [23:0] filter_sample(logic signed [23:0] smp);
        t_lane  g1, g2, g3, g4, t, s;
        longint taps[4];
        longint x, k, acc, y, sum;
        k = longint'(cut_gain);
        x = longint'(smp) * 16;
        for (int os = 0; os < 4; os++) begin
            for (int i = 0; i < 4; i++) s[i] = ladder[i];
            ladder_slopes(s, x, g1);
            for (int i = 0; i < 4; i++) t[i] = s[i] + fdiv(k * g1[i], 131072);
            ladder_slopes(t, x, g2);
            for (int i = 0; i < 4; i++) t[i] = s[i] + fdiv(k * g2[i], 131072);
            ladder_slopes(t, x, g3);
            for (int i = 0; i < 4; i++) t[i] = s[i] + fdiv(k * g3[i], 65536);
            ladder_slopes(t, x, g4);
            for (int i = 0; i < 4; i++) begin
                sum = g1[i] + 2 * g2[i] + 2 * g3[i] + g4[i];
                ladder[i] = s[i] + fdiv(k * sum, 393216);
                if (ladder[i] > 64'sd2147483647) ladder[i] = 64'sd2147483647;
                if (ladder[i] < -64'sd2147483648) ladder[i] = -64'sd2147483648;
            end
            taps[os] = ladder[3];
            x = 0;
        end
        acc = longint'(W_TAP0) * taps[0] + longint'(W_TAP2) * taps[2]
            + longint'(W_TAP3) * taps[3];
        y = fdiv(acc * 3, 64'sd536870912);
        if (y > OUT_MAX) y = OUT_MAX;
        if (y < OUT_MIN) y = OUT_MIN;
        return y[23:0];
    endfunction

    // monitor: sample both channels, predict on input beats, check output beats
    always @(posedge i_clk) begin
        logic signed [23:0] want;
        in_took = 1'b0;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                in_took = 1'b1;
                filtered_q.push_back(filter_sample(i_sample_in));
            end
            if (o_out_valid && !i_out_stall) begin
                if (filtered_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected output beat: sample_out=%0d", o_sample_out);
                end else begin
                    want = filtered_q.pop_front();
                    if (o_sample_out !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("sample_out mismatch: expected %0d, got %0d",
                                     want, o_sample_out);
                    end
                end
            end
            if (in_took || (o_out_valid && !i_out_stall) || (i_cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("FAIL rk4_ladder_lowpass_filter");
                $finish;
            end
        end
    end

    // sender: hold a stalled beat, otherwise offer the next sample or idle
    always @(negedge i_clk) begin
        if (running && (!i_in_valid || in_took)) begin
            if (sample_q.size() > 0 && $urandom_range(99) >= snd_idle) begin
                i_in_valid <= 1'b1;
                i_sample_in <= sample_q.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver: random stall plus an occasional long hold-off
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (hold_req != hold_ack) begin
            hold_ack = hold_ack + 1;
            hold_left = LONG_HOLD;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < rcv_idle);
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_STEP_GAIN: cut_gain = val;
            REG_RESONANCE: res_amt = val;
            REG_GAIN_COMP: comp_amt = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (sample_q.size() != 0 || i_in_valid || filtered_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic add_random(int n);
        logic signed [23:0] v;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(3))
                0: v = 24'($urandom);
                1: v = $signed(24'($urandom_range(4095))) - 24'sd2048;
                2: v = $urandom_range(1) ? 24'sh7FFFFF : -24'sh800000;
                default: v = $signed(24'($urandom_range(1048575))) - 24'sd524288;
            endcase
            // repeat the value now and then to form steps the ladder can settle on
            for (int r = $urandom_range(3) == 0 ? $urandom_range(6) : 0; r >= 0; r--)
                sample_q.push_back(v);
        end
    endtask

    task automatic set_regs(logic [15:0] gk, logic [15:0] rs, logic [15:0] gc);
        write_reg(REG_STEP_GAIN, gk);
        write_reg(REG_RESONANCE, rs);
        write_reg(REG_GAIN_COMP, gc);
    endtask

    initial begin
        for (int i = 0; i < 4; i++) ladder[i] = 0;
        cut_gain = STEP_GAIN_RST;
        res_amt = '0;
        comp_amt = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        running = 1'b1;
        snd_idle = 18;
        rcv_idle = 71;

        // directed: field extremes and steps at reset settings
        sample_q = '{24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, -24'sh800000, -24'sh800000,
                     24'sd0, 24'sd1, -24'sd1, 24'sh555555, -24'sh555556, 24'sh100000,
                     24'sh100000, 24'sd0, 24'sd0};
        drain();

        // extremes of all registers, then saturate the stages
        set_regs(16'hFFFF, 16'd36864, 16'hFFFF);
        sample_q = '{24'sh7FFFFF, 24'sh7FFFFF, -24'sh800000, -24'sh800000, 24'sd0,
                     24'sh7FFFFF, 24'sd0, -24'sd1};
        add_random(80);
        hold_req++;
        drain();

        set_regs(16'd0, 16'd0, 16'd0);
        add_random(20);
        drain();

        // resonance far past its range, plus a write to an unused index
        set_regs(16'd40000, 16'hFFFF, 16'd12345);
        write_reg(REG_UNUSED, 16'hBEEF);
        sample_q = '{24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, -24'sh800000,
                     -24'sh800000, -24'sh800000};
        add_random(80);
        drain();

        snd_idle = 71;
        rcv_idle = 18;
        for (int p = 0; p < 3; p++) begin
            set_regs(16'($urandom), 16'($urandom_range(36864)), 16'($urandom));
            add_random(75);
            drain();
        end

        snd_idle = 0;
        rcv_idle = 0;
        set_regs(16'd20000, 16'd30000, 16'd40000);
        add_random(40);
        while (sample_q.size() != 0) @(posedge i_clk);
        // sender pauses here until every result is out
        drain();
        add_random(40);
        hold_req++;
        drain();
        set_regs(16'($urandom), 16'($urandom_range(36864)), 16'($urandom));
        add_random(75);
        drain();

        repeat (SETTLE) @(posedge i_clk);
        if (mismatches == 0 && filtered_q.size() == 0)
            $display("PASS rk4_ladder_lowpass_filter");
        else
            $display("FAIL rk4_ladder_lowpass_filter");
        $finish;
    end

endmodule
